// ===== rtl/core/integer_to_ascii_radix_unit_macros.svh =====
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_MACROS_SVH

// Condition must hold on every edge outside reset.
`define ITOA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ITOA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/itoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int CNT_W = ($clog2(MAX_WIDTH + 1) > 6) ? $clog2(MAX_WIDTH + 1) : 6;

  localparam int DIG_N     = 16;
  localparam int DIG_IDX_W = 4;
  localparam int ND_W      = 5;

  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int          DEC_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CMD_DEC   = 2'd0,
    CMD_OCT   = 2'd1,
    CMD_HEX32 = 2'd2,
    CMD_HEX64 = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] value;
    logic [5:0]  min_width;
    logic        zero_pad;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  typedef struct packed {
    radix_t             radix;
    logic [63:0]        mag;
    logic               neg;
    logic [CNT_W-1:0]   width;
    logic               zpad;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end else begin
      return CH_A + d8 - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itoa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire itoa_pkg::in_item_t request,
  output logic                   job_valid,
  input  wire logic              job_take,
  output itoa_pkg::job_t         job
);

  itoa_pkg::job_t job_in;
  logic [31:0]    low;
  logic [31:0]    low_neg;

  itoa_pkg::job_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    low     = request.value[31:0];
    low_neg = 32'd0 - low;
    job_in.zpad  = request.zero_pad;
    job_in.width = (itoa_pkg::CNT_W'(request.min_width) >
                    itoa_pkg::CNT_W'(itoa_pkg::MAX_WIDTH)) ?
                   itoa_pkg::CNT_W'(itoa_pkg::MAX_WIDTH) :
                   itoa_pkg::CNT_W'(request.min_width);
    job_in.neg   = 1'b0;
    job_in.radix = itoa_pkg::RADIX_HEX;
    job_in.mag   = {32'd0, low};
    case (request.command)
      itoa_pkg::CMD_DEC: begin
        job_in.radix = itoa_pkg::RADIX_DEC;
        job_in.neg   = low[31];
        job_in.mag   = {32'd0, (low[31] ? low_neg : low)};
      end
      itoa_pkg::CMD_OCT: begin
        job_in.radix = itoa_pkg::RADIX_OCT;
      end
      itoa_pkg::CMD_HEX32: begin
        job_in.radix = itoa_pkg::RADIX_HEX;
      end
      itoa_pkg::CMD_HEX64: begin
        job_in.radix = itoa_pkg::RADIX_HEX;
        job_in.mag   = request.value;
      end
      default: begin
        job_in.radix = itoa_pkg::RADIX_HEX;
      end
    endcase
  end

  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = queue[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/itoa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  output logic                    job_take,
  input  wire itoa_pkg::job_t     job,
  output logic                    empty,
  input  wire logic               pop,
  output itoa_pkg::out_item_t     result
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DIGIT = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t                       state;
  itoa_pkg::radix_t             radix;
  logic [63:0]                  mag;
  logic                         neg;
  logic [itoa_pkg::CNT_W-1:0]   width;
  logic                         zpad;
  logic [itoa_pkg::ND_W-1:0]    nd;
  logic [3:0]                   digs [itoa_pkg::DIG_N];
  logic [itoa_pkg::CNT_W-1:0]   pos;
  logic [itoa_pkg::CNT_W-1:0]   total;
  logic [itoa_pkg::CNT_W-1:0]   dig_start;
  logic                         out_valid;
  itoa_pkg::out_item_t          out_item;

  logic [63:0]                        prod;
  logic [63-itoa_pkg::DEC_SHIFT:0]    quot;
  logic [31:0]                        q32;
  logic [31:0]                        q10;
  logic [31:0]                        rem;
  logic [3:0]                         digit;
  logic [63:0]                        mag_next;
  logic [itoa_pkg::ND_W-1:0]          nd_inc;
  logic [itoa_pkg::CNT_W-1:0]         body;
  logic [itoa_pkg::CNT_W-1:0]         total_calc;
  logic [itoa_pkg::CNT_W-1:0]         sign_pos;
  logic [itoa_pkg::CNT_W-1:0]         rev;
  logic [itoa_pkg::DIG_IDX_W-1:0]     rd_idx;
  logic [7:0]                         ch;
  logic                               ch_last;
  logic                               out_free;

  // Decimal digit: quotient by reciprocal multiply, remainder by shift-add.
  always_comb begin
    prod = 64'(mag[31:0]) * 64'(itoa_pkg::DEC_RECIP);
    quot = prod[63:itoa_pkg::DEC_SHIFT];
    q32  = 32'(quot);
    q10  = (q32 << 3) + (q32 << 1);
    rem  = mag[31:0] - q10;
    case (radix)
      itoa_pkg::RADIX_DEC: begin
        digit    = rem[3:0];
        mag_next = {32'd0, q32};
      end
      itoa_pkg::RADIX_OCT: begin
        digit    = {1'b0, mag[2:0]};
        mag_next = mag >> 3;
      end
      itoa_pkg::RADIX_HEX: begin
        digit    = mag[3:0];
        mag_next = mag >> 4;
      end
      default: begin
        digit    = mag[3:0];
        mag_next = mag >> 4;
      end
    endcase
    nd_inc     = nd + itoa_pkg::ND_W'(1);
    body       = itoa_pkg::CNT_W'(nd_inc) + itoa_pkg::CNT_W'(neg);
    total_calc = (body > width) ? body : width;
  end

  always_comb begin
    sign_pos = zpad ? '0 : (dig_start - itoa_pkg::CNT_W'(1));
    rev      = total - pos - itoa_pkg::CNT_W'(1);
    rd_idx   = rev[itoa_pkg::DIG_IDX_W-1:0];
    if (pos >= dig_start) begin
      ch = itoa_pkg::digit_char(digs[rd_idx]);
    end else if (neg && (pos == sign_pos)) begin
      ch = itoa_pkg::CH_MINUS;
    end else begin
      ch = zpad ? itoa_pkg::CH_ZERO : itoa_pkg::CH_SPACE;
    end
    ch_last = (pos == total - itoa_pkg::CNT_W'(1));
  end

  assign out_free = !out_valid || pop;
  assign job_take = (state == S_IDLE);
  assign empty    = !out_valid;
  assign result   = out_item;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      radix <= job.radix;
      mag   <= job.mag;
      neg   <= job.neg;
      width <= job.width;
      zpad  <= job.zpad;
    end else if (state == S_DIGIT) begin
      mag                                 <= mag_next;
      digs[nd[itoa_pkg::DIG_IDX_W-1:0]]   <= digit;
      if (mag_next == 64'd0) begin
        total     <= total_calc;
        dig_start <= total_calc - itoa_pkg::CNT_W'(nd_inc);
      end
    end
    if (state == S_EMIT && out_free) begin
      out_item.character <= ch;
      out_item.last      <= ch_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      nd        <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            nd    <= '0;
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          nd <= nd_inc;
          if (mag_next == 64'd0) begin
            pos   <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            pos <= pos + itoa_pkg::CNT_W'(1);
            if (ch_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_ascii_radix_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Integer to ASCII converter. Each pushed item (mode, value, minimum width,
// zero-pad flag) comes out as a string of characters, most significant first,
// one per popped result, with last set on the final one. Modes: signed
// decimal, octal, 32-bit hex and 64-bit hex, uppercase digits, padded to the
// minimum width (capped at itoa_pkg::MAX_WIDTH) with spaces before the sign or
// zeros after it. A two-item queue sits in front of the converter, so pushes
// are taken while a conversion runs. An item is loaded, then its D digits are
// formed (D = number of digits, 1 to 16; a decimal digit takes one 32x32
// reciprocal multiply), then N = max(width, D + sign) characters are emitted
// one at a time through the output register, held back while a waiting
// result is not popped.
module integer_to_ascii_radix_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire itoa_pkg::in_item_t  request,
  output logic                     empty,
  input  wire logic                pop,
  output itoa_pkg::out_item_t      result
);

  logic           job_valid;
  logic           job_take;
  itoa_pkg::job_t job;

  itoa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== rtl/core/itoa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_radix_unit_macros.svh"

module itoa_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                push,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire itoa_pkg::out_item_t result
);

  // Items accepted but whose last character is not yet popped.
  logic [2:0] pending;
  logic       in_acc;
  logic       done_acc;

  assign in_acc   = push && !full;
  assign done_acc = pop && !empty && result.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + {2'b0, in_acc} - {2'b0, done_acc};
    end
  end

  // Two queued, one converting, one final character waiting in the output register.
  `ITOA_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result), "result moved")
  `ITOA_ASSERT_IMPLY(a_idle_quiet, pending == 3'd0, empty && !full, "busy with nothing pending")
  `ITOA_ASSERT_ALWAYS(a_pending_bound, pending <= 3'd4, "more items in flight than storage")
  `ITOA_ASSERT_IMPLY(a_reset_clean, $past(rst), empty && !full, "not clean after reset")

endmodule

bind integer_to_ascii_radix_unit itoa_checker u_itoa_checker (.*);

`default_nettype wire
